/* hdl/tfp_pkg.sv */
// ----------------------------------------------------------------------------
// tfp_pkg
// Types, constants and a helper shared by the touch frame parser modules.
// ----------------------------------------------------------------------------
package tfp_pkg;

  localparam int MAX_CONTACTS = 5;
  localparam int CONTACT_SIZE = 5;
  localparam int ROW_BITS     = 8 * CONTACT_SIZE;
  localparam int ROW_W        = (MAX_CONTACTS > 1) ? $clog2(MAX_CONTACTS) : 1;
  localparam int CNT_W        = $clog2(MAX_CONTACTS + 1);
  localparam int BYTE_CNT_W   = $clog2(CONTACT_SIZE);
  localparam int QUEUE_DEPTH  = 2;
  localparam int QP_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QC_W         = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] STAT_MASK  = 8'hc0;
  localparam logic [7:0] STAT_READY = 8'h80;

  localparam logic [1:0] ST_VALID     = 2'd0;
  localparam logic [1:0] ST_NOT_READY = 2'd1;
  localparam logic [1:0] ST_CSUM_ERR  = 2'd2;

  typedef enum logic [1:0] {
    PH_WAIT,
    PH_KEY,
    PH_DATA,
    PH_SUM
  } phase_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_SEND
  } back_state_t;

  typedef enum logic [1:0] {
    CMD_EMIT,
    CMD_NOT_READY,
    CMD_CSUM_ERR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                 kind;
    logic [MAX_CONTACTS-1:0]   mask;
  } cmd_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  slot_index;
    logic        touch_down;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [7:0]  touch_width;
    logic [1:0]  frame_status;
    logic        last_result;
  } out_item_t;

  function automatic logic [CNT_W-1:0] count_ones(input logic [MAX_CONTACTS-1:0] v);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < MAX_CONTACTS; i++) begin
      n = n + CNT_W'(v[i]);
    end
    return n;
  endfunction

endpackage

/* hdl/tfp_ram.sv */
// ----------------------------------------------------------------------------
// tfp_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module tfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/tfp_front.sv */
// ----------------------------------------------------------------------------
// tfp_front
// Byte parser: tracks the frame phase, checks status and checksum, packs
// contact bytes into rows and issues commands to the result side.
// ----------------------------------------------------------------------------
module tfp_front import tfp_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  in_item_t            in_data,
  output logic                in_stall,
  input  logic                q_full,
  input  logic                store_busy,
  output logic                push,
  output cmd_t                push_cmd,
  output logic                wr_en,
  output logic [ROW_W-1:0]    wr_addr,
  output logic [ROW_BITS-1:0] wr_data
);

  phase_t                  phase, phase_next;
  logic [MAX_CONTACTS-1:0] mask;
  logic [CNT_W-1:0]        nfing;
  logic [ROW_W-1:0]        row;
  logic [BYTE_CNT_W-1:0]   byte_cnt;
  logic [7:0]              sum;
  logic [ROW_BITS-9:0]     shift;

  logic accept;
  logic status_ok;
  logic contact_end;
  logic last_row;

  assign in_stall    = q_full || (phase == PH_DATA && store_busy);
  assign accept      = in_valid && !in_stall;
  assign status_ok   = (in_data.data_byte & STAT_MASK) == STAT_READY;
  assign contact_end = byte_cnt == BYTE_CNT_W'(CONTACT_SIZE - 1);
  assign last_row    = (CNT_W'(row) + CNT_W'(1)) == nfing;

  always_comb begin
    phase_next = phase;
    if (accept) begin
      if (in_data.frame_start) begin
        phase_next = status_ok ? PH_KEY : PH_WAIT;
      end else begin
        case (phase)
          PH_KEY:  phase_next = (nfing == '0) ? PH_WAIT : PH_DATA;
          PH_DATA: if (contact_end && last_row) phase_next = PH_SUM;
          PH_SUM:  phase_next = PH_WAIT;
          default: phase_next = PH_WAIT;
        endcase
      end
    end
  end

  always_comb begin
    push          = 1'b0;
    push_cmd.kind = CMD_EMIT;
    push_cmd.mask = mask;
    wr_en         = 1'b0;
    wr_addr       = row;
    wr_data       = {shift, in_data.data_byte};
    if (accept) begin
      if (in_data.frame_start) begin
        if (!status_ok) begin
          push          = 1'b1;
          push_cmd.kind = CMD_NOT_READY;
        end
      end else begin
        case (phase)
          PH_KEY: push = nfing == '0;
          PH_DATA: wr_en = contact_end;
          PH_SUM: begin
            push          = 1'b1;
            push_cmd.kind = (in_data.data_byte == sum) ? CMD_EMIT : CMD_CSUM_ERR;
          end
          default: push = 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_WAIT;
      mask     <= '0;
      nfing    <= '0;
      row      <= '0;
      byte_cnt <= '0;
      sum      <= '0;
    end else begin
      phase <= phase_next;
      if (accept) begin
        if (in_data.frame_start) begin
          row      <= '0;
          byte_cnt <= '0;
          sum      <= '0;
          if (status_ok) begin
            mask  <= in_data.data_byte[MAX_CONTACTS-1:0];
            nfing <= count_ones(in_data.data_byte[MAX_CONTACTS-1:0]);
          end else begin
            mask  <= '0;
            nfing <= '0;
          end
        end else if (phase == PH_DATA) begin
          sum <= sum + in_data.data_byte;
          if (contact_end) begin
            byte_cnt <= '0;
            row      <= row + ROW_W'(1);
          end else begin
            byte_cnt <= byte_cnt + BYTE_CNT_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !in_data.frame_start && phase == PH_DATA) begin
      shift <= {shift[ROW_BITS-17:0], in_data.data_byte};
    end
  end

endmodule

/* hdl/tfp_queue.sv */
// ----------------------------------------------------------------------------
// tfp_queue
// Short command queue between parser and result side; counts pending emits.
// ----------------------------------------------------------------------------
module tfp_queue import tfp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic full,
  output logic empty,
  output logic emit_pending
);

  cmd_t            entries [QUEUE_DEPTH];
  logic [QP_W-1:0] wr_ptr;
  logic [QP_W-1:0] rd_ptr;
  logic [QC_W-1:0] count;
  logic [QC_W-1:0] emit_cnt;
  logic            push_emit;
  logic            pop_emit;

  assign head         = entries[rd_ptr];
  assign full         = count == QC_W'(QUEUE_DEPTH);
  assign empty        = count == '0;
  assign emit_pending = emit_cnt != '0;
  assign push_emit    = push && push_cmd.kind == CMD_EMIT;
  assign pop_emit     = pop && head.kind == CMD_EMIT;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      count    <= '0;
      emit_cnt <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QP_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QP_W'(1);
      end
      count    <= count + QC_W'(push) - QC_W'(pop);
      emit_cnt <= emit_cnt + QC_W'(push_emit) - QC_W'(pop_emit);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

/* hdl/tfp_back.sv */
// ----------------------------------------------------------------------------
// tfp_back
// Result side: takes commands, reads contact rows and drives the result
// output register.
// ----------------------------------------------------------------------------
module tfp_back import tfp_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  cmd_t                q_head,
  output logic                pop,
  output logic                emit_busy,
  output logic                rd_en,
  output logic [ROW_W-1:0]    rd_addr,
  input  logic [ROW_BITS-1:0] rd_data,
  output logic                out_valid,
  input  logic                out_stall,
  output out_item_t           out_data
);

  back_state_t             state, state_next;
  cmd_kind_t               kind;
  logic [MAX_CONTACTS-1:0] mask;
  logic [ROW_W-1:0]        slot;
  logic [ROW_W-1:0]        row;
  logic                    out_free;
  logic                    load;
  logic                    last_slot;
  out_item_t               res;

  assign out_free  = !out_valid || !out_stall;
  assign last_slot = slot == ROW_W'(MAX_CONTACTS - 1);
  assign emit_busy = state != BK_IDLE && kind == CMD_EMIT;

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: if (!q_empty) state_next = (q_head.kind == CMD_EMIT) ? BK_READ : BK_SEND;
      BK_READ: state_next = BK_SEND;
      BK_SEND: begin
        if (out_free) begin
          state_next = (kind != CMD_EMIT || last_slot) ? BK_IDLE : BK_READ;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop     = state == BK_IDLE && !q_empty;
    rd_en   = state == BK_READ;
    rd_addr = row;
    load    = state == BK_SEND && out_free;
    res     = '0;
    case (kind)
      CMD_EMIT: begin
        res.slot_index   = 3'(slot);
        res.touch_down   = mask[slot];
        res.frame_status = ST_VALID;
        res.last_result  = last_slot;
        if (mask[slot]) begin
          res.pos_x       = rd_data[ROW_BITS-1 -: 16];
          res.pos_y       = rd_data[ROW_BITS-17 -: 16];
          res.touch_width = rd_data[7:0];
        end
      end
      CMD_NOT_READY: begin
        res.frame_status = ST_NOT_READY;
        res.last_result  = 1'b1;
      end
      CMD_CSUM_ERR: begin
        res.frame_status = ST_CSUM_ERR;
        res.last_result  = 1'b1;
      end
      default: res.last_result = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind <= q_head.kind;
      mask <= q_head.mask;
      slot <= '0;
      row  <= '0;
    end else if (load) begin
      slot <= slot + ROW_W'(1);
      if (mask[slot]) begin
        row <= row + ROW_W'(1);
      end
    end
    if (load) begin
      out_data <= res;
    end
  end

endmodule

/* hdl/touch_frame_parser.sv */
// ----------------------------------------------------------------------------
// touch_frame_parser
// Parses touch report frames byte by byte and emits per-slot contact results or a status result.
// ----------------------------------------------------------------------------
//   channel | direction | payload     | transfer when
//   in      | input     | in_item_t   | in_valid && !in_stall
//   out     | output    | out_item_t  | out_valid && !out_stall
//
// The parser takes one byte per cycle while in_stall is low; contact bytes
// are packed into rows of a small RAM. Each slot result on the result side
// is a row read, then an output register load; status and checksum errors
// need only the load after the command is popped. Data bytes of a new frame
// stall while rows of the previous frame are still being read out. No
// clearing pass after reset.
// ----------------------------------------------------------------------------
module touch_frame_parser import tfp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  in_item_t  in_data,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic                push;
  cmd_t                push_cmd;
  logic                pop;
  cmd_t                head;
  logic                q_full;
  logic                q_empty;
  logic                emit_pending;
  logic                emit_busy;
  logic                wr_en;
  logic [ROW_W-1:0]    wr_addr;
  logic [ROW_BITS-1:0] wr_data;
  logic                rd_en;
  logic [ROW_W-1:0]    rd_addr;
  logic [ROW_BITS-1:0] rd_data;

  tfp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .in_stall   (in_stall),
    .q_full     (q_full),
    .store_busy (emit_pending || emit_busy),
    .push       (push),
    .push_cmd   (push_cmd),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  tfp_queue u_queue (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .push_cmd     (push_cmd),
    .pop          (pop),
    .head         (head),
    .full         (q_full),
    .empty        (q_empty),
    .emit_pending (emit_pending)
  );

  tfp_ram #(
    .WIDTH (ROW_BITS),
    .DEPTH (MAX_CONTACTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tfp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (head),
    .pop       (pop),
    .emit_busy (emit_busy),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* bench/tfp_checker.sv */
// ----------------------------------------------------------------------------
// tfp_checker
// Watches both channels of the touch frame parser. Keeps its own copy of the
// parse state, predicts the results of every accepted byte and compares each
// result transfer with the oldest prediction. Hands the failure count and
// the number of outstanding results to the bench top.
// ----------------------------------------------------------------------------
module tfp_checker import tfp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  in_item_t  in_data,
  input  logic      in_stall,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        fail_count,
  output int        pending_results
);

  localparam int STORE_DEPTH = CONTACT_SIZE * MAX_CONTACTS;

  phase_t                  phase;
  logic [MAX_CONTACTS-1:0] fingers;
  int                      need_bytes;
  int                      taken_bytes;
  logic [7:0]              byte_sum;
  logic [7:0]              contact_store [STORE_DEPTH];
  out_item_t               expected_reports [$];

  function automatic out_item_t status_report(input logic [1:0] status);
    out_item_t r;
    r = '0;
    r.frame_status = status;
    r.last_result  = 1'b1;
    return r;
  endfunction

  function automatic string describe(input out_item_t r);
    return $sformatf("slot=%0d down=%0d x=%h y=%h w=%h status=%0d last=%0d",
                     r.slot_index, r.touch_down, r.pos_x, r.pos_y, r.touch_width,
                     r.frame_status, r.last_result);
  endfunction

  task automatic queue_slot_reports();
    out_item_t r;
    int        p;
    p = 0;
    for (int i = 0; i < MAX_CONTACTS; i++) begin
      r = '0;
      r.slot_index   = 3'(i);
      r.frame_status = ST_VALID;
      r.last_result  = (i == MAX_CONTACTS - 1);
      if (fingers[i]) begin
        r.touch_down  = 1'b1;
        r.pos_x       = {contact_store[p], contact_store[p + 1]};
        r.pos_y       = {contact_store[p + 2], contact_store[p + 3]};
        r.touch_width = contact_store[p + 4];
        p += CONTACT_SIZE;
      end
      expected_reports.push_back(r);
    end
  endtask

  task automatic parse_frame_byte(input in_item_t it);
    if (it.frame_start) begin
      taken_bytes = 0;
      byte_sum    = '0;
      if ((it.data_byte & STAT_MASK) != STAT_READY) begin
        phase   = PH_WAIT;
        fingers = '0;
        expected_reports.push_back(status_report(ST_NOT_READY));
      end else begin
        fingers    = it.data_byte[MAX_CONTACTS-1:0];
        need_bytes = CONTACT_SIZE * $countones(fingers);
        phase      = PH_KEY;
      end
    end else begin
      case (phase)
        PH_KEY: begin
          if (need_bytes == 0) begin
            phase = PH_WAIT;
            queue_slot_reports();
          end else begin
            phase = PH_DATA;
          end
        end
        PH_DATA: begin
          contact_store[taken_bytes] = it.data_byte;
          byte_sum = byte_sum + it.data_byte;
          taken_bytes++;
          if (taken_bytes >= need_bytes) phase = PH_SUM;
        end
        PH_SUM: begin
          phase = PH_WAIT;
          if (it.data_byte != byte_sum) begin
            expected_reports.push_back(status_report(ST_CSUM_ERR));
          end else begin
            queue_slot_reports();
          end
        end
        default: phase = PH_WAIT;
      endcase
    end
  endtask

  task automatic check_report(input out_item_t got);
    out_item_t want;
    if (expected_reports.size() == 0) begin
      if (fail_count < 10) $display("unexpected result: %s", describe(got));
      fail_count++;
    end else begin
      want = expected_reports.pop_front();
      if (got !== want) begin
        if (fail_count < 10) begin
          $display("result mismatch");
          $display("  expected: %s", describe(want));
          $display("  actual:   %s", describe(got));
        end
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      phase       = PH_WAIT;
      fingers     = '0;
      need_bytes  = 0;
      taken_bytes = 0;
      byte_sum    = '0;
      fail_count  = 0;
      expected_reports.delete();
    end else begin
      if (in_valid && !in_stall) parse_frame_byte(in_data);
      if (out_valid && !out_stall) check_report(out_data);
    end
    pending_results <= expected_reports.size();
  end

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Bench for the touch frame parser. Sends a short directed set of frames,
// then random frames (mostly well formed, some cut short, not ready, with a
// bad checksum or trailed by stray bytes) under several idle and stall
// mixes, including a long receiver hold. Checking is done by tfp_checker.
// ----------------------------------------------------------------------------
module tb_top import tfp_pkg::*; ();

  logic      clk = 1'b0;
  logic      rst;
  logic      in_valid;
  in_item_t  in_data;
  logic      in_stall;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  int        fail_count;
  int        pending_results;

  int        send_gap_pct;
  int        recv_stall_pct;
  bit        long_hold;
  int        byte_count;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  touch_frame_parser i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  tfp_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_data         (in_data),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial begin
    #(12 * 300000);
    $display("TEST FAILED");
    $finish;
  end

  // receiver: random stalls, or one long hold on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
      end
      out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic start, input bit counted = 1'b1);
    while (send_gap_pct != 0 && $urandom_range(99, 0) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, frame_start: start};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (counted) byte_count++;
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] contact_value();
    case ($urandom_range(9, 0))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_random_frame();
    logic [MAX_CONTACTS-1:0] mask;
    logic [7:0]              status;
    logic [7:0]              sum;
    logic [7:0]              b;
    int                      body_len;
    int                      cut;
    case ($urandom_range(9, 0))
      0:       mask = '0;
      1:       mask = '1;
      default: mask = MAX_CONTACTS'($urandom);
    endcase
    status = 8'($urandom);
    status[7:6] = 2'b10;
    status[MAX_CONTACTS-1:0] = mask;
    if ($urandom_range(99, 0) < 12) begin
      status[7:6] = ($urandom_range(2, 0) == 2) ? 2'b11 : 2'($urandom_range(1, 0));
    end
    send_byte(status, 1'b1);
    body_len = 0;
    cut = 0;
    if ((status & STAT_MASK) == STAT_READY) begin
      body_len = 1 + CONTACT_SIZE * $countones(mask);
      if (body_len > 1) body_len++;
      cut = ($urandom_range(99, 0) < 8) ? $urandom_range(body_len - 1, 0) : body_len;
      sum = '0;
      for (int i = 0; i < cut; i++) begin
        if (i == 0) begin
          b = 8'($urandom);
        end else if (i == body_len - 1) begin
          b = sum;
          if ($urandom_range(99, 0) < 20) b = sum + 8'($urandom_range(255, 1));
        end else begin
          b = contact_value();
          sum = sum + b;
        end
        send_byte(b, 1'b0);
      end
    end
    // stray bytes only after a frame that was not cut short
    if (cut == body_len && $urandom_range(99, 0) < 10) begin
      for (int k = 0; k < $urandom_range(3, 1); k++) send_byte(8'($urandom), 1'b0, 1'b0);
    end
  endtask

  initial begin
    int target;
    rst            <= 1'b1;
    in_valid       <= 1'b0;
    in_data        <= '0;
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    long_hold      = 1'b0;
    byte_count     = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_byte(8'h55, 1'b0, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hc0, 1'b1);
    send_byte(8'h7f, 1'b1);
    send_byte(8'h80, 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(8'h90, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'hfd, 1'b0);
    send_byte(8'ha1, 1'b1);
    send_byte(8'h5a, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'hff, 1'b1);
    send_byte(8'h82, 1'b1);
    send_byte(8'ha5, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h04, 1'b0);
    send_byte(8'h05, 1'b0);
    send_byte(8'h00, 1'b0);
    wait_for_drain();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          send_gap_pct   = 0;
          recv_stall_pct = 0;
          long_hold      = 1'b1;
        end
        1: begin
          send_gap_pct   = 69;
          recv_stall_pct = 0;
        end
        2: begin
          send_gap_pct   = 0;
          recv_stall_pct = 69;
        end
        default: begin
          send_gap_pct   = 34;
          recv_stall_pct = 34;
        end
      endcase
      target = byte_count + 102;
      while (byte_count < target) send_random_frame();
      wait_for_drain();
    end

    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
